// File: hw/rtl/mrf_pkg.sv
// Shared types, constants and CRC helper for the Modbus RTU request framer.
// No dependencies; imported by the framer modules.
package mrf_pkg;

   // Modbus function codes the framer accepts
   localparam logic [7:0] FC_READ_COILS    = 8'd1;
   localparam logic [7:0] FC_READ_DISCRETE = 8'd2;
   localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FC_READ_INPUT    = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
   localparam logic [7:0] FC_WRITE_REG     = 8'd6;
   localparam logic [7:0] FC_WRITE_MULTI   = 8'd16;

   localparam logic [15:0] COIL_ON_WORD  = 16'hFF00;
   localparam logic [15:0] COIL_OFF_WORD = 16'h0000;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;

   // Frame bytes ahead of the CRC: at most 11
   localparam int DATA_BYTES = 11;
   localparam int DATA_W     = DATA_BYTES * 8;
   localparam int LEN_W      = 4;

   localparam logic [LEN_W-1:0] LEN_FIXED     = 4'd6;
   localparam logic [LEN_W-1:0] LEN_MULTI_NONE = 4'd7;
   localparam logic [LEN_W-1:0] LEN_MULTI_ONE  = 4'd9;
   localparam logic [LEN_W-1:0] LEN_MULTI_TWO  = 4'd11;

   typedef struct packed {
      logic [LEN_W-1:0]  len;
      logic [DATA_W-1:0] bytes;   // first byte in the top bits
   } mrf_desc_type;

   typedef struct packed {
      logic empty;
      logic full;
   } mrf_q_stat_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_DATA,
      SEQ_CRC_LO,
      SEQ_CRC_HI
   } mrf_seq_type;

   // Modbus CRC-16, one byte folded in, reflected form
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: hw/rtl/mrf_if.sv
// Handshake channels of the framer: request in, frame bytes out.
// No dependencies.
interface mrf_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  kind;
   logic [7:0]  slave_address;
   logic [15:0] start_address;
   logic [15:0] quantity;
   logic        coil_on;
   logic [15:0] value_first;
   logic [15:0] value_second;
   logic [15:0] write_count;

   modport source (output valid, kind, slave_address, start_address, quantity, coil_on,
                   value_first, value_second, write_count, input ready);
   modport sink (input valid, kind, slave_address, start_address, quantity, coil_on,
                 value_first, value_second, write_count, output ready);
endinterface

interface mrf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] frame_byte;
   logic       last_byte;

   modport source (output valid, frame_byte, last_byte, input ready);
   modport sink (input valid, frame_byte, last_byte, output ready);
endinterface

// File: hw/rtl/mrf_front.sv
// Request front end: classifies the function code and lays out the frame body.
// Depends on mrf_pkg and mrf_req_if.
module mrf_front
   import mrf_pkg::*;
(
   mrf_req_if.sink        req_ch,
   input  mrf_q_stat_type q_stat,
   output logic           push,
   output mrf_desc_type   desc
);

   logic        framed;
   logic [15:0] body_word;
   logic [7:0]  cnt_twice;

   always_comb begin
      framed    = 1'b1;
      body_word = req_ch.quantity;
      case (req_ch.kind)
         FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
            body_word = req_ch.quantity;
         end
         FC_WRITE_COIL: begin
            body_word = req_ch.coil_on ? COIL_ON_WORD : COIL_OFF_WORD;
         end
         FC_WRITE_REG: begin
            body_word = req_ch.value_first;
         end
         FC_WRITE_MULTI: begin
            body_word = req_ch.write_count;
         end
         default: begin
            framed = 1'b0;
         end
      endcase
   end

   // byte count field wraps to 8 bits
   assign cnt_twice = {req_ch.write_count[6:0], 1'b0};

   always_comb begin
      desc.bytes = {req_ch.slave_address, req_ch.kind, req_ch.start_address, body_word,
                    cnt_twice, req_ch.value_first, req_ch.value_second};
      if (req_ch.kind == FC_WRITE_MULTI) begin
         if (req_ch.write_count == 16'd0) begin
            desc.len = LEN_MULTI_NONE;
         end else if (req_ch.write_count == 16'd1) begin
            desc.len = LEN_MULTI_ONE;
         end else begin
            desc.len = LEN_MULTI_TWO;
         end
      end else begin
         desc.len = LEN_FIXED;
      end
   end

   // drop unknown codes at accept
   assign req_ch.ready = !q_stat.full;
   assign push         = req_ch.valid && !q_stat.full && framed;

endmodule

// File: hw/rtl/mrf_queue.sv
// Two-entry descriptor queue between the front end and the byte sequencer.
// Depends on mrf_pkg.
module mrf_queue
   import mrf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  mrf_desc_type   push_desc,
   input  logic           pop,
   output mrf_desc_type   head_desc,
   output mrf_q_stat_type q_stat
);

   mrf_desc_type entry_ff [2];
   logic         wr_ptr_ff, wr_ptr_in;
   logic         rd_ptr_ff, rd_ptr_in;
   logic [1:0]   count_ff, count_in;
   logic         do_push, do_pop;

   assign q_stat.empty = (count_ff == 2'd0);
   assign q_stat.full  = (count_ff == 2'd2);
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && !q_stat.empty;
   assign head_desc    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

// File: hw/rtl/mrf_back.sv
// Byte sequencer: shifts out the frame body, folds each byte into the CRC,
// appends the CRC low byte first. Depends on mrf_pkg and mrf_rsp_if.
module mrf_back
   import mrf_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  mrf_q_stat_type q_stat,
   input  mrf_desc_type   head_desc,
   output logic           pop,
   mrf_rsp_if.source      rsp_ch
);

   mrf_seq_type       state_ff, state_in;
   logic [DATA_W-1:0] shift_ff, shift_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   logic [15:0]       crc_ff, crc_in;
   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic       advance;
   logic       load;
   logic       crc_step;
   logic       emit;
   logic [7:0] emit_byte;
   logic       emit_last;

   // output slot free or being taken this cycle
   assign advance = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (!q_stat.empty) begin
               state_in = SEQ_DATA;
            end
         end
         SEQ_DATA: begin
            if (advance && left_ff == 4'd1) begin
               state_in = SEQ_CRC_LO;
            end
         end
         SEQ_CRC_LO: begin
            if (advance) begin
               state_in = SEQ_CRC_HI;
            end
         end
         SEQ_CRC_HI: begin
            if (advance) begin
               state_in = SEQ_IDLE;
            end
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   always_comb begin
      load      = 1'b0;
      crc_step  = 1'b0;
      emit      = 1'b0;
      emit_byte = shift_ff[DATA_W-1 -: 8];
      emit_last = 1'b0;
      case (state_ff)
         SEQ_IDLE: begin
            load = !q_stat.empty;
         end
         SEQ_DATA: begin
            crc_step = advance;
            emit     = advance;
         end
         SEQ_CRC_LO: begin
            emit      = advance;
            emit_byte = crc_ff[7:0];
         end
         SEQ_CRC_HI: begin
            emit      = advance;
            emit_byte = crc_ff[15:8];
            emit_last = 1'b1;
         end
         default: begin
            load = 1'b0;
         end
      endcase
   end

   assign pop = load;

   always_comb begin
      shift_in     = shift_ff;
      left_in      = left_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (load) begin
         shift_in = head_desc.bytes;
         left_in  = head_desc.len;
         crc_in   = CRC_INIT;
      end
      if (crc_step) begin
         shift_in = {shift_ff[DATA_W-9:0], 8'h00};
         left_in  = left_ff - 4'd1;
         crc_in   = crc_byte(crc_ff, shift_ff[DATA_W-1 -: 8]);
      end
      if (emit) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= SEQ_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff    <= shift_in;
      left_ff     <= left_in;
      crc_ff      <= crc_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.frame_byte = out_byte_ff;
   assign rsp_ch.last_byte  = out_last_ff;

endmodule

// File: hw/rtl/modbus_rtu_request_framer.sv
// Modbus RTU request framer. Each accepted request becomes one frame of 8, 9, 11
// or 13 bytes on rsp_ch, last_byte marking the second CRC byte; unknown function
// codes are accepted while the queue has room and produce nothing. In the byte
// sequencer a frame starts with a load step, then goes out one byte per cycle
// while rsp_ch is ready, the CRC-16 folding in each body byte as it goes out.
// A two-entry request queue lets req_ch accept while a frame is still going out.
// Depends on mrf_pkg, mrf_if, mrf_front, mrf_queue, mrf_back.
module modbus_rtu_request_framer
   import mrf_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   mrf_req_if.sink   req_ch,
   mrf_rsp_if.source rsp_ch
);

   mrf_q_stat_type q_stat;
   mrf_desc_type   push_desc;
   mrf_desc_type   head_desc;
   logic           push;
   logic           pop;

   mrf_front u_front (
      .req_ch (req_ch),
      .q_stat (q_stat),
      .push   (push),
      .desc   (push_desc)
   );

   mrf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head_desc (head_desc),
      .q_stat    (q_stat)
   );

   mrf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .head_desc (head_desc),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule
